FILE: sv/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants for the palette fade blend block.
// ----------------------------------------------------------------------------
package pfb_pkg;

    localparam int CHAN_W   = 5;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int INDEX_W  = 8;
    localparam int WEIGHT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W  = 24;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 5'd16;

    localparam logic FUNC_BLEND = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_COEFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_COEFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_COLOR = 2'd2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One blend job handed from the front to the back.
    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic [COLOR_W-1:0]  color;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
        logic                fin;
    } t_item;

endpackage

FILE: sv/pfb_front.sv
// ----------------------------------------------------------------------------
// pfb_front
// Accepts input transactions, runs the fade state and queues blend jobs.
// ----------------------------------------------------------------------------
module pfb_front
    import pfb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_func,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [COLOR_W-1:0]  i_color,
    input  logic                i_last,
    input  logic [WEIGHT_W-1:0] i_start_coeff,
    input  logic [WEIGHT_W-1:0] i_end_coeff,
    input  logic                i_full,
    output logic                o_push,
    output t_item               o_item
);

    logic [WEIGHT_W-1:0] r_weight, n_weight;
    logic                r_running, n_running;
    logic                accept;
    logic [WEIGHT_W-1:0] start_sat;
    logic [WEIGHT_W-1:0] end_sat;
    logic                fin;

    function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
        return (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
    endfunction

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign start_sat = sat_weight(i_start_coeff);
    assign end_sat   = sat_weight(i_end_coeff);

    always_comb begin
        n_weight  = r_weight;
        n_running = r_running;
        fin       = 1'b0;
        if (accept) begin
            if (i_func == FUNC_START) begin
                if (!r_running) begin
                    n_weight  = start_sat;
                    n_running = 1'b1;
                end
            end else if (r_running && i_last) begin
                if (r_weight == end_sat) begin
                    n_running = 1'b0;
                    fin       = 1'b1;
                end else if (r_weight > end_sat) begin
                    n_weight = r_weight - 1'b1;
                end else begin
                    n_weight = r_weight + 1'b1;
                end
            end
        end
    end

    // Idle blends and start items produce no job.
    assign o_push        = accept && (i_func == FUNC_BLEND) && r_running;
    assign o_item.index  = i_index;
    assign o_item.color  = i_color;
    assign o_item.weight = r_weight;
    assign o_item.last   = i_last;
    assign o_item.fin    = fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight  <= '0;
            r_running <= 1'b0;
        end else begin
            r_weight  <= n_weight;
            r_running <= n_running;
        end
    end

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_START && !r_running)
            |=> (r_running && r_weight == $past(start_sat)))
        else $error("start did not arm the fade");

    a_end_has_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_running) |-> $past(o_push && o_item.fin))
        else $error("fade ended without a finishing job");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_weight <= WEIGHT_MAX)
        else $error("weight above sixteen");

endmodule

FILE: sv/pfb_queue.sv
// ----------------------------------------------------------------------------
// pfb_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module pfb_queue
    import pfb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
    endfunction

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

FILE: sv/pfb_back.sv
// ----------------------------------------------------------------------------
// pfb_back
// Blends queued entries toward the blend color into the output register.
// ----------------------------------------------------------------------------
module pfb_back
    import pfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_pop,
    input  logic [COLOR_W-1:0] i_blend_color,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COLOR_W-1:0] o_color,
    output logic [INDEX_W-1:0] o_index,
    output logic               o_last,
    output logic               o_fin
);

    logic               r_valid;
    logic [COLOR_W-1:0] r_color;
    logic [INDEX_W-1:0] r_index;
    logic               r_last;
    logic               r_fin;
    logic [COLOR_W-1:0] mixed;

    // c1 + floor((c2 - c1) * w / 16), wrapped to five bits.
    function automatic logic [CHAN_W-1:0] mix_channel(
        input logic [CHAN_W-1:0]   c1,
        input logic [CHAN_W-1:0]   c2,
        input logic [WEIGHT_W-1:0] w
    );
        logic signed [CHAN_W:0]     d;
        logic signed [2*CHAN_W+1:0] p;
        d = $signed({1'b0, c2}) - $signed({1'b0, c1});
        p = d * $signed({1'b0, w});
        return CHAN_W'(c1 + p[CHAN_W+3:4]);
    endfunction

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            mixed[ch*CHAN_W +: CHAN_W] = mix_channel(i_item.color[ch*CHAN_W +: CHAN_W],
                                                     i_blend_color[ch*CHAN_W +: CHAN_W],
                                                     i_item.weight);
        end
    end

    assign o_pop = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_color <= mixed;
            r_index <= i_item.index;
            r_last  <= i_item.last;
            r_fin   <= i_item.fin;
        end
    end

    assign o_valid = r_valid;
    assign o_color = r_color;
    assign o_index = r_index;
    assign o_last  = r_last;
    assign o_fin   = r_fin;

    a_fin_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_fin) |-> r_last)
        else $error("finish flag on an entry that is not last");

endmodule

FILE: sv/palette_fade_blend.sv
// ----------------------------------------------------------------------------
// palette_fade_blend
// Fades RGB555 palette entries toward a programmable blend color.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake                    Payload
// -------  ---  ---------------------------  ----------------------------------
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata{color,index} tuser func tlast
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata{index,color} tuser fin tlast
// cfg      in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained in both directions while m_axis_tready is
// high; an accepted blend item passes a queue slot, then the output register.
// The fade state lives in the front, so start items and frame ends take effect
// for the very next transaction.
// Synchronous active-low reset clears the fade, the queue and the output
// register, and loads the register defaults (start 16, end 0, color black).
// Output stalls fill the two-entry queue; s_axis_tready drops only when full.
//
module palette_fade_blend
    import pfb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] entry_index, [22:8] entry_color, [23] zero
    input  logic [TDATA_W-1:0]   s_axis_tdata,
    // [0] func
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [14:0] faded_color, [22:15] out_index, [23] zero
    output logic [TDATA_W-1:0]   m_axis_tdata,
    // [0] fade_finished
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    logic [WEIGHT_W-1:0] r_start_coeff;
    logic [WEIGHT_W-1:0] r_end_coeff;
    logic [COLOR_W-1:0]  r_blend_color;
    logic                cfg_wr;

    logic   q_push, q_full, q_valid, q_pop;
    t_item  q_in, q_out;

    logic [COLOR_W-1:0] out_color;
    logic [INDEX_W-1:0] out_index;

    // Config writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_coeff <= WEIGHT_MAX;
            r_end_coeff   <= '0;
            r_blend_color <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_START_COEFF: r_start_coeff <= i_cfg_data[WEIGHT_W-1:0];
                CFG_END_COEFF:   r_end_coeff   <= i_cfg_data[WEIGHT_W-1:0];
                CFG_BLEND_COLOR: r_blend_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pfb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_func        (s_axis_tuser),
        .i_index       (s_axis_tdata[INDEX_W-1:0]),
        .i_color       (s_axis_tdata[INDEX_W +: COLOR_W]),
        .i_last        (s_axis_tlast),
        .i_start_coeff (r_start_coeff),
        .i_end_coeff   (r_end_coeff),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_item        (q_in)
    );

    pfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_out)
    );

    pfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_item        (q_out),
        .o_pop         (q_pop),
        .i_blend_color (r_blend_color),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_color       (out_color),
        .o_index       (out_index),
        .o_last        (m_axis_tlast),
        .o_fin         (m_axis_tuser)
    );

    // Pack the result: color low, index above it, pad to whole bytes.
    assign m_axis_tdata = {{(TDATA_W - COLOR_W - INDEX_W){1'b0}}, out_index, out_color};

endmodule
